// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on aclk with active-low aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked at every edge
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/core/crcf_pkg.sv =====
package crcf_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF      = 2;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  ACK_BYTE    = 8'hFF;
    localparam logic [7:0]  CLAMP_MAX   = 8'd127;
    localparam logic [7:0]  RETRIES_RST = 8'd2;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    localparam logic [2:0]  IDX_CRC_HI  = 3'd3;
    localparam logic [2:0]  IDX_LAST    = 3'd4;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_REPLY = 2'd1,
        OP_TICK  = 2'd2
    } crcf_op_t;

    typedef enum logic [1:0] {
        STATUS_ACK     = 2'd0,
        STATUS_FAIL    = 2'd1,
        STATUS_TIMEOUT = 2'd2,
        STATUS_BUSY    = 2'd3
    } crcf_status_t;

    typedef enum logic {
        CFG_MAX_RETRIES   = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } crcf_cfg_idx_t;

    typedef enum logic {
        KIND_FRAME  = 1'b0,
        KIND_STATUS = 1'b1
    } crcf_kind_t;

    typedef struct packed {
        crcf_kind_t   kind;
        crcf_status_t status;
        logic [7:0]   b0;
        logic [7:0]   b1;
        logic [7:0]   b2;
    } crcf_cmd_t;

    typedef struct packed {
        logic      push;
        crcf_cmd_t cmd;
    } crcf_push_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crcf_front.sv =====
module crcf_front
    import crcf_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        accept,
    input  logic [1:0]  opcode,
    input  logic [7:0]  dest_address,
    input  logic [7:0]  command_code,
    input  logic [7:0]  value,
    input  logic        clamp_value,
    input  logic [7:0]  reply_byte,
    output crcf_push_t  q_push
);

    localparam int TW    = TICK_COUNT_WIDTH;
    localparam int CMP_W = (TW > 16) ? TW : 16;

    logic [7:0]    max_retries_reg;
    logic [15:0]   timeout_reg;
    logic [7:0]    held_reg [3];
    logic [7:0]    retries_reg, retries_next;
    logic          awaiting_reg, awaiting_next;
    logic [TW-1:0] wait_reg, wait_next, wait_inc;
    logic          load_frame;
    logic [7:0]    value_clamped;
    crcf_push_t    push_next;

    assign value_clamped = (clamp_value && (value > CLAMP_MAX)) ? CLAMP_MAX : value;
    assign wait_inc      = (wait_reg == '1) ? wait_reg : wait_reg + 1'b1;

    always_comb begin
        retries_next   = retries_reg;
        awaiting_next  = awaiting_reg;
        wait_next      = wait_reg;
        load_frame     = 1'b0;
        push_next.push = 1'b0;
        push_next.cmd  = '{kind: KIND_FRAME, status: STATUS_ACK,
                           b0: held_reg[0], b1: held_reg[1], b2: held_reg[2]};
        if (accept) begin
            case (crcf_op_t'(opcode))
                OP_SEND: begin
                    push_next.push = 1'b1;
                    if (awaiting_reg) begin
                        push_next.cmd.kind   = KIND_STATUS;
                        push_next.cmd.status = STATUS_BUSY;
                    end else begin
                        load_frame        = 1'b1;
                        retries_next      = max_retries_reg;
                        awaiting_next     = 1'b1;
                        wait_next         = '0;
                        push_next.cmd.b0  = dest_address;
                        push_next.cmd.b1  = command_code;
                        push_next.cmd.b2  = value_clamped;
                    end
                end
                OP_REPLY: begin
                    if (awaiting_reg) begin
                        push_next.push = 1'b1;
                        if (reply_byte == ACK_BYTE) begin
                            awaiting_next        = 1'b0;
                            push_next.cmd.kind   = KIND_STATUS;
                            push_next.cmd.status = STATUS_ACK;
                        end else if (retries_reg != '0) begin
                            retries_next = retries_reg - 1'b1;
                            wait_next    = '0;
                        end else begin
                            awaiting_next        = 1'b0;
                            push_next.cmd.kind   = KIND_STATUS;
                            push_next.cmd.status = STATUS_FAIL;
                        end
                    end
                end
                OP_TICK: begin
                    if (awaiting_reg) begin
                        wait_next = wait_inc;
                        if (CMP_W'(wait_inc) >= CMP_W'(timeout_reg)) begin
                            awaiting_next        = 1'b0;
                            push_next.push       = 1'b1;
                            push_next.cmd.kind   = KIND_STATUS;
                            push_next.cmd.status = STATUS_TIMEOUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign q_push = push_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= RETRIES_RST;
            timeout_reg     <= TIMEOUT_RST;
            retries_reg     <= '0;
            awaiting_reg    <= 1'b0;
            wait_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                case (crcf_cfg_idx_t'(cfg_index))
                    CFG_MAX_RETRIES:   max_retries_reg <= cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
                    default: begin
                    end
                endcase
            end
            retries_reg  <= retries_next;
            awaiting_reg <= awaiting_next;
            wait_reg     <= wait_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_frame) begin
            held_reg[0] <= dest_address;
            held_reg[1] <= command_code;
            held_reg[2] <= value_clamped;
        end
    end

endmodule

// ===== rtl/core/crcf_queue.sv =====
module crcf_queue
    import crcf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  crcf_push_t q_push,
    input  logic       pop,
    output logic       full,
    output logic       q_valid,
    output crcf_cmd_t  q_head
);

`include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crcf_cmd_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push.push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (q_push.push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!q_push.push && pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            mem[wr_ptr_reg] <= q_push.cmd;
        end
    end

    `ASSERT_RST(a_no_overflow, q_push.push |-> !full, "push into full queue")
    `ASSERT_RST(a_no_underflow, pop |-> q_valid, "pop from empty queue")

endmodule

// ===== rtl/core/crcf_back.sv =====
module crcf_back
    import crcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  crcf_cmd_t  q_head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_tx_byte,
    output logic [1:0] m_status,
    output logic       m_last
);

`include "assert_macros.svh"

    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [7:0]  m_byte_reg;
    logic [1:0]  m_status_reg;
    logic        m_last_reg;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        advance;
    logic        is_last;
    logic [7:0]  byte_next;

    assign advance = q_valid && (!m_valid_reg || m_ready);
    assign is_last = (q_head.kind == KIND_STATUS) || (idx_reg == IDX_LAST);
    assign pop     = advance && is_last;

    always_comb begin
        crc_next  = crc_reg;
        byte_next = '0;
        case (idx_reg)
            3'd0: begin
                byte_next = q_head.b0;
                crc_next  = crc_byte(16'h0000, q_head.b0);
            end
            3'd1: begin
                byte_next = q_head.b1;
                crc_next  = crc_byte(crc_reg, q_head.b1);
            end
            3'd2: begin
                byte_next = q_head.b2;
                crc_next  = crc_byte(crc_reg, q_head.b2);
            end
            IDX_CRC_HI: byte_next = crc_reg[15:8];
            IDX_LAST:   byte_next = crc_reg[7:0];
            default:    byte_next = '0;
        endcase
        idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= idx_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_last_reg <= is_last;
            if (q_head.kind == KIND_STATUS) begin
                m_kind_reg   <= 1'b1;
                m_byte_reg   <= '0;
                m_status_reg <= q_head.status;
            end else begin
                m_kind_reg   <= 1'b0;
                m_byte_reg   <= byte_next;
                m_status_reg <= STATUS_ACK;
                crc_reg      <= crc_next;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_tx_byte     = m_byte_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

    `ASSERT_RST(a_status_last, m_valid_reg && m_kind_reg |-> m_last_reg,
        "status result without last")
    `ASSERT_RST(a_idx_idle, !q_valid |-> idx_reg == 3'd0, "byte index left mid-frame")

endmodule

// ===== rtl/core/crc16_command_framer_with_retry.sv =====
// channel   direction  handshake                   payload
// s_        in         s_valid / s_ready           opcode, address, command, value, clamp, reply
// m_        out        m_valid / m_ready           result kind, tx byte, status, last
// cfg_      in         cfg_valid / cfg_ready       register index, write data
//
// a new send, or a retry on a non-ack reply, yields five results, one per cycle while m_ready holds;
// a busy send yields one status; the single output register of the back end paces the results
// other items yield at most one status result
// the front end stalls only when the two-entry command queue is full
// reset is synchronous and active low; no clearing pass, ready right after reset
module crc16_command_framer_with_retry
    import crcf_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_dest_address,
    input  logic [7:0]  s_command_code,
    input  logic [7:0]  s_value,
    input  logic        s_clamp_value,
    input  logic [7:0]  s_reply_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_tx_byte,
    output logic [1:0]  m_status,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    crcf_push_t q_push;
    crcf_cmd_t  q_head;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;

    crcf_front #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (s_valid && s_ready),
        .opcode       (s_opcode),
        .dest_address (s_dest_address),
        .command_code (s_command_code),
        .value        (s_value),
        .clamp_value  (s_clamp_value),
        .reply_byte   (s_reply_byte),
        .q_push       (q_push)
    );

    crcf_queue #(
        .DEPTH(QUEUE_DEPTH_DEF)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .pop     (q_pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    crcf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_tx_byte     (m_tx_byte),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule
